@@ rtl/core/gwm_pkg.sv @@
// ----------------------------------------------------------------------------
// gwm_pkg
// Shared types and constants for the greedy wildcard matcher.
// ----------------------------------------------------------------------------
package gwm_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int ADDR_W      = $clog2(MAX_PATTERN);
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_TEXT   = 2'd2,
        KIND_END    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        V_UNDECIDED = 2'd0,
        V_REJECT    = 2'd1,
        V_ACCEPT    = 2'd2
    } t_verdict;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_WALK = 4'b0100,
        S_ENDW = 4'b1000
    } t_state;

    typedef struct packed {
        logic clear;
        logic append;
        logic text;
        logic eval;
        logic walk;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic undecided;
        logic eval_star;
        logic walk_more;
    } t_stat;

    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[CH_UP_A:CH_UP_Z]}) begin
            r = c + CASE_OFS;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/gwm_ctrl.sv @@
// ----------------------------------------------------------------------------
// gwm_ctrl
// Sequencer: takes input beats, steps the datapath through evaluate and
// star-run walk, and owns the result beat valid.
// ----------------------------------------------------------------------------
module gwm_ctrl
    import gwm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [1:0]  i_kind,
    output logic        o_ready,
    output logic        o_valid,
    input  logic        i_ready,
    input  t_stat       i_stat,
    output t_cmd        o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_kind)
                        KIND_CLEAR:  o_cmd.clear = 1'b1;
                        KIND_APPEND: o_cmd.append = 1'b1;
                        KIND_TEXT: begin
                            if (i_stat.undecided) begin
                                o_cmd.text = 1'b1;
                                n_state    = S_EVAL;
                            end
                        end
                        KIND_END: begin
                            if (out_free) begin
                                o_cmd.finish = 1'b1;
                                n_out_valid  = 1'b1;
                            end else begin
                                n_state = S_ENDW;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_stat.eval_star ? S_WALK : S_IDLE;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (!i_stat.walk_more) begin
                    n_state = S_IDLE;
                end
            end
            S_ENDW: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_finish_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!r_out_valid || i_ready))
        else $error("result overwritten while pending");

    a_walk_from_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && i_stat.eval_star) |=> (r_state == S_WALK))
        else $error("star run walk not entered");

    a_endw_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ENDW && !out_free) |=> (r_state == S_ENDW))
        else $error("end of text left before result slot freed");

endmodule

@@ rtl/core/gwm_dpath.sv @@
// ----------------------------------------------------------------------------
// gwm_dpath
// Pattern store, match position, seek flag, verdict and result registers.
// ----------------------------------------------------------------------------
module gwm_dpath
    import gwm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_ch,
    output t_stat       o_stat,
    output logic        o_matched,
    output logic        o_pattern_overflow
);

    logic [7:0]       mem [MAX_PATTERN];
    logic [7:0]       r_rd_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]       r_ch;
    logic [LEN_W-1:0] r_pos, n_pos;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_seek, n_seek;
    t_verdict         r_verdict, n_verdict;
    logic             r_ovf, n_ovf;
    logic             r_matched, r_pat_ovf;
    logic [LEN_W-1:0] pos_inc;
    logic             pos_lt_len;
    logic             len_full;
    logic             star_or_q;
    logic             end_ok;

    assign pos_inc    = r_pos + LEN_W'(1);
    assign pos_lt_len = (r_pos < r_len);
    assign len_full   = (r_len >= LEN_W'(MAX_PATTERN));
    assign star_or_q  = (r_rd_data inside {CH_STAR, CH_QMARK});
    assign rd_addr    = (i_cmd.eval || i_cmd.walk) ? pos_inc[ADDR_W-1:0]
                                                   : r_pos[ADDR_W-1:0];

    assign o_stat.undecided = (r_verdict == V_UNDECIDED);
    assign o_stat.eval_star = !r_seek && pos_lt_len && (r_rd_data == CH_STAR);
    assign o_stat.walk_more = pos_lt_len && star_or_q;

    assign o_matched          = r_matched;
    assign o_pattern_overflow = r_pat_ovf;

    always_comb begin
        case (r_verdict)
            V_ACCEPT:    end_ok = 1'b1;
            V_REJECT:    end_ok = 1'b0;
            V_UNDECIDED: end_ok = !r_seek && !pos_lt_len;
            default:     end_ok = 1'b0;
        endcase
    end

    always_comb begin
        n_pos     = r_pos;
        n_len     = r_len;
        n_seek    = r_seek;
        n_verdict = r_verdict;
        n_ovf     = r_ovf;
        if (i_cmd.clear) begin
            n_len     = '0;
            n_ovf     = 1'b0;
            n_pos     = '0;
            n_seek    = 1'b0;
            n_verdict = V_UNDECIDED;
        end else if (i_cmd.append) begin
            if (len_full) begin
                n_ovf = 1'b1;
            end else begin
                n_len = r_len + LEN_W'(1);
            end
        end else if (i_cmd.eval) begin
            if (r_seek) begin
                if (pos_lt_len && (r_ch == r_rd_data)) begin
                    n_seek = 1'b0;
                    n_pos  = pos_inc;
                end
            end else if (!pos_lt_len) begin
                n_verdict = V_REJECT;
            end else if (star_or_q) begin
                n_pos = pos_inc;
            end else if (fold_lower(r_ch) != fold_lower(r_rd_data)) begin
                n_verdict = V_REJECT;
            end else begin
                n_pos = pos_inc;
            end
        end else if (i_cmd.walk) begin
            if (pos_lt_len && star_or_q) begin
                n_pos = pos_inc;
            end else if (!pos_lt_len) begin
                n_verdict = V_ACCEPT;
            end else begin
                n_seek = 1'b1;
            end
        end else if (i_cmd.finish) begin
            n_pos     = '0;
            n_seek    = 1'b0;
            n_verdict = V_UNDECIDED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && !len_full) begin
            mem[r_len[ADDR_W-1:0]] <= i_ch;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.text) begin
            r_ch <= i_ch;
        end
        if (i_cmd.finish) begin
            r_matched <= end_ok;
            r_pat_ovf <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_len     <= '0;
            r_seek    <= 1'b0;
            r_verdict <= V_UNDECIDED;
            r_ovf     <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_seek    <= n_seek;
            r_verdict <= n_verdict;
            r_ovf     <= n_ovf;
        end
    end

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= r_len)
        else $error("match position past pattern end");

    a_seek_undecided: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seek |-> (r_verdict == V_UNDECIDED))
        else $error("seeking with verdict decided");

    a_finish_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_pos == '0 && !r_seek && r_verdict == V_UNDECIDED))
        else $error("text state not restarted after end of text");

endmodule

@@ rtl/core/greedy_wildcard_matcher.sv @@
// ----------------------------------------------------------------------------
// greedy_wildcard_matcher
// Greedy, non-backtracking wildcard matcher over a stored pattern.
//
//   channel  handshake           payload
//   -------  ------------------  ------------------------------------
//   input    i_valid / o_ready   i_kind[1:0], i_ch[7:0]
//   result   o_valid / i_ready   o_matched, o_pattern_overflow
//
// Clear, append and end-of-text beats are handled in the idle state; a text
// beat reads the pattern store in idle, then compares in the evaluate state.
// A star then adds a walk over its following run of stars and '?' through
// the single store read port. Text after a decided verdict is not evaluated.
// Synchronous active-low reset; no clearing pass, the store is filled by
// appends. An end-of-text beat waits while the previous result is unread.
// ----------------------------------------------------------------------------
module greedy_wildcard_matcher
    import gwm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_ch,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_matched,
    output logic        o_pattern_overflow
);

    t_cmd  cmd;
    t_stat stat;

    gwm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    gwm_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_ch               (i_ch),
        .o_stat             (stat),
        .o_matched          (o_matched),
        .o_pattern_overflow (o_pattern_overflow)
    );

endmodule

@@ tb/tb_greedy_wildcard_matcher.sv @@
// ----------------------------------------------------------------------------
// tb_greedy_wildcard_matcher
// Self-checking bench for the greedy wildcard matcher. Patterns and text are
// streamed in through the beat channel, mostly as well-formed sessions that
// are built from the loaded pattern. A scoreboard class mirrors the pattern
// store and the match state and checks every verdict in order. Both sides
// idle at random, and one long receiver hold-off backs up the input side.
// ----------------------------------------------------------------------------
module tb_greedy_wildcard_matcher
    import gwm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT   = 400000;
    localparam int TARGET_BEATS = 1200;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic matched;
        logic overflow;
    } t_result;

    class verdict_scoreboard;
        logic [7:0] pat[MAX_PATTERN];
        int         pat_len;
        int         pat_pos;
        bit         seeking;
        t_verdict   verdict;
        bit         ovf;
        t_result    pending_verdicts[$];
        int         mismatches;
        int         verdicts_checked;
        int         matches_seen;
        int         overflows_seen;

        function new();
            pat_len = 0;
            ovf     = 1'b0;
            restart_text();
        endfunction

        function void restart_text();
            pat_pos = 0;
            seeking = 1'b0;
            verdict = V_UNDECIDED;
        endfunction

        function logic [7:0] to_lower(logic [7:0] c);
            return (c >= CH_UP_A && c <= CH_UP_Z) ? c + 8'd32 : c;
        endfunction

        function void advance_text(logic [7:0] c);
            logic [7:0] p;
            if (verdict != V_UNDECIDED) return;
            if (seeking) begin
                if (pat_pos < pat_len && c == pat[pat_pos]) begin
                    seeking = 1'b0;
                    pat_pos++;
                end
                return;
            end
            if (pat_pos >= pat_len) begin
                verdict = V_REJECT;
                return;
            end
            p = to_lower(pat[pat_pos]);
            if (p == CH_STAR) begin
                pat_pos++;
                while (pat_pos < pat_len &&
                       (pat[pat_pos] == CH_STAR || pat[pat_pos] == CH_QMARK))
                    pat_pos++;
                if (pat_pos >= pat_len) verdict = V_ACCEPT;
                else seeking = 1'b1;
            end else if (p == CH_QMARK) begin
                pat_pos++;
            end else if (to_lower(c) != p) begin
                verdict = V_REJECT;
            end else begin
                pat_pos++;
            end
        endfunction

        function void take_beat(t_kind k, logic [7:0] c);
            t_result v;
            case (k)
                KIND_CLEAR: begin
                    pat_len = 0;
                    ovf     = 1'b0;
                    restart_text();
                end
                KIND_APPEND: begin
                    if (pat_len < MAX_PATTERN) begin
                        pat[pat_len] = c;
                        pat_len++;
                    end else begin
                        ovf = 1'b1;
                    end
                end
                KIND_TEXT: advance_text(c);
                default: begin
                    if (verdict == V_ACCEPT) v.matched = 1'b1;
                    else if (verdict == V_REJECT || seeking) v.matched = 1'b0;
                    else v.matched = (pat_pos >= pat_len);
                    v.overflow = ovf;
                    pending_verdicts.push_back(v);
                    restart_text();
                end
            endcase
        endfunction

        function void check_verdict(logic m, logic o);
            t_result want;
            if (pending_verdicts.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected verdict beat: matched=%0b overflow=%0b", m, o);
                mismatches++;
                return;
            end
            want = pending_verdicts.pop_front();
            verdicts_checked++;
            if (m === 1'b1) matches_seen++;
            if (o === 1'b1) overflows_seen++;
            if (m !== want.matched || o !== want.overflow) begin
                if (mismatches < 10)
                    $display("verdict mismatch: exp m=%0b o=%0b, got m=%0b o=%0b",
                             want.matched, want.overflow, m, o);
                mismatches++;
            end
        endfunction
    endclass

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       i_valid  = 1'b0;
    logic [1:0] i_kind   = KIND_CLEAR;
    logic [7:0] i_ch     = 8'h00;
    logic       i_ready  = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic       o_matched;
    logic       o_pattern_overflow;

    verdict_scoreboard sb = new();
    int  cyc        = 0;
    int  beats_sent = 0;
    bit  hold_req   = 1'b0;
    bit  hold_done  = 1'b0;
    logic [7:0] pat_q[$];

    greedy_wildcard_matcher dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_kind             (i_kind),
        .i_ch               (i_ch),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_matched          (o_matched),
        .o_pattern_overflow (o_pattern_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= RUN_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_verdict(o_matched, o_pattern_overflow);
    end

    // result side: random back-pressure, one long hold-off, calm windows
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                i_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            if ((cyc % 5000) < 1200) i_ready = 1'b1;
            else i_ready = ($urandom_range(0, 99) >= 11);
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_beat(input t_kind k, input logic [7:0] c);
        if (!(beats_sent >= 400 && beats_sent < 650)) begin
            while ($urandom_range(0, 99) < 11) begin
                i_valid = 1'b0;
                @(negedge i_clk);
            end
        end
        i_valid = 1'b1;
        i_kind  = k;
        i_ch    = c;
        do @(posedge i_clk); while (!o_ready);
        sb.take_beat(k, c);
        beats_sent++;
        if (k == KIND_CLEAR) pat_q.delete();
        else if (k == KIND_APPEND) pat_q.push_back(c);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_pattern_char();
        case ($urandom_range(0, 11))
            0, 1:    return CH_STAR;
            2:       return CH_QMARK;
            3:       return "a";
            4:       return "b";
            5:       return "A";
            6:       return "B";
            7:       return "c";
            8:       return "Z";
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_filler();
        case ($urandom_range(0, 5))
            0:       return "a";
            1:       return "b";
            2:       return "c";
            3:       return "B";
            4:       return "x";
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // text shaped after the current pattern, with some damage thrown in
    task automatic send_text_for_pattern();
        logic [7:0] snap[$];
        logic [7:0] p;
        int         n;
        snap = pat_q;
        foreach (snap[i]) begin
            if ($urandom_range(0, 29) == 0) break;
            p = snap[i];
            if (p == CH_STAR) begin
                n = $urandom_range(1, 3);
                repeat (n) send_beat(KIND_TEXT, pick_filler());
            end else if (p == CH_QMARK) begin
                send_beat(KIND_TEXT, 8'($urandom_range(0, 255)));
            end else begin
                case ($urandom_range(0, 7))
                    0:       send_beat(KIND_TEXT, p ^ CASE_OFS);
                    1:       send_beat(KIND_TEXT, pick_filler());
                    default: send_beat(KIND_TEXT, p);
                endcase
            end
            if (i == snap.size() / 2 && $urandom_range(0, 9) == 0)
                send_beat(KIND_APPEND, pick_pattern_char());
        end
        if ($urandom_range(0, 7) == 0) send_beat(KIND_TEXT, pick_filler());
        send_beat(KIND_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic run_session();
        int plen;
        int ntext;
        if ($urandom_range(0, 99) < 85) begin
            if ($urandom_range(0, 9) != 0) begin
                send_beat(KIND_CLEAR, 8'($urandom_range(0, 255)));
                plen = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70)
                                                    : $urandom_range(1, 8);
                repeat (plen) send_beat(KIND_APPEND, pick_pattern_char());
            end
            ntext = $urandom_range(1, 4);
            repeat (ntext) send_text_for_pattern();
        end else begin
            repeat ($urandom_range(1, 6))
                send_beat(t_kind'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty pattern, empty text
        send_beat(KIND_END, 8'h00);
        // star then '?' run, case folding on plain compares
        send_beat(KIND_CLEAR, 8'hFF);
        send_beat(KIND_APPEND, "a");
        send_beat(KIND_APPEND, CH_STAR);
        send_beat(KIND_APPEND, CH_QMARK);
        send_beat(KIND_APPEND, "c");
        send_beat(KIND_TEXT, "A");
        send_beat(KIND_TEXT, "x");
        send_beat(KIND_TEXT, "x");
        send_beat(KIND_TEXT, "c");
        send_beat(KIND_END, 8'hFF);
        // literal wait is case-sensitive
        send_beat(KIND_TEXT, "a");
        send_beat(KIND_TEXT, "X");
        send_beat(KIND_TEXT, "C");
        send_beat(KIND_END, 8'h00);
        // high bytes, then a trailing star
        send_beat(KIND_CLEAR, 8'h00);
        send_beat(KIND_APPEND, 8'hFF);
        send_beat(KIND_APPEND, 8'h00);
        send_beat(KIND_TEXT, 8'hFF);
        send_beat(KIND_TEXT, 8'h00);
        send_beat(KIND_END, 8'h00);
        send_beat(KIND_APPEND, CH_STAR);
        send_beat(KIND_TEXT, 8'hFF);
        send_beat(KIND_TEXT, 8'h00);
        send_beat(KIND_TEXT, "z");
        send_beat(KIND_END, 8'h00);
        // empty text against a non-empty pattern
        send_beat(KIND_END, 8'h00);

        hold_req = 1'b1;
        while (beats_sent < TARGET_BEATS) run_session();

        i_valid = 1'b0;
        while (sb.pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d beats driven, %0d verdicts checked: %0d matches, %0d with overflow",
                 beats_sent, sb.verdicts_checked, sb.matches_seen, sb.overflows_seen);
        $display("receiver hold-off of %0d cycles done: %0b", HOLD_CYCLES, hold_done);
        if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
